/* rtl/pro_pkg.sv */
// pro_pkg: shared types and constants for the polyline rail offset block.
// Used by the top level, pro_front, pro_queue and pro_back; depends on nothing.
`default_nettype none
package pro_pkg;
    localparam int CoordWidth = 32;
    localparam int DiffWidth  = CoordWidth + 1;
    localparam int HalfWidth  = 13;
    localparam logic [HalfWidth-1:0] HalfReset = 13'd735;

    typedef logic signed [CoordWidth-1:0] t_coord;
    typedef logic [DiffWidth-1:0] t_mag;

    // one job for the back end: vertex and tangent as sign and magnitude
    typedef struct packed {
        t_coord     px;
        t_coord     py;
        t_mag       mx;
        logic       nx;
        t_mag       my;
        logic       ny;
        logic       last;
    } t_job;

    localparam int JobWidth = $bits(t_job);
endpackage
`default_nettype wire

/* rtl/polyline_rail_offset.sv */
// polyline_rail_offset: top level, front end, job queue and back end.
// Depends on pro_pkg, pro_front, pro_queue, pro_back.
//
// Usage: vertices of a polyline enter on i_valid/o_stall with i_point_x,
// i_point_y and i_last_point. Rail points leave on o_valid/i_stall, one
// item per vertex, with o_last_vertex on the final vertex's item.
// A vertex is emitted once its successor has arrived; the arrival of the
// final vertex gives two items, its predecessor's and its own. The half
// gauge is written on i_cfg_valid/o_cfg_ready (always ready); the user
// must write it only while the block is idle, which the block itself does
// not enforce. Each item passes the queue, then the shared back end: take,
// normalize, square, sum, root, two divisions, multiply, output. A zero
// tangent goes from normalize straight to output. The back end takes a
// new job only once it has finished the last one.
// A four entry queue decouples front and back so the front keeps taking
// items while the back end works. When the receiver stalls the output
// register holds and the back end waits; the queue then fills and o_stall
// rises. Synchronous active-low reset empties queue and pipeline, clears
// the pending vertex and sets the half gauge to 735.
`default_nettype none
module polyline_rail_offset (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  pro_pkg::t_coord            i_point_x,
    input  pro_pkg::t_coord            i_point_y,
    input  wire                        i_last_point,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [pro_pkg::HalfWidth-1:0] i_cfg_data,
    output logic                       o_valid,
    input  wire                        i_stall,
    output pro_pkg::t_coord            o_left_x,
    output pro_pkg::t_coord            o_left_y,
    output pro_pkg::t_coord            o_right_x,
    output pro_pkg::t_coord            o_right_y,
    output logic                       o_last_vertex
);
    logic [pro_pkg::HalfWidth-1:0] r_half;
    logic w_push, w_full, w_qv, w_take;
    pro_pkg::t_job w_job_in, w_job_out;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_half <= pro_pkg::HalfReset;
        else if (i_cfg_valid) r_half <= i_cfg_data;
    end

    pro_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_last_point(i_last_point),
        .o_job_valid(w_push), .i_job_full(w_full), .o_job(w_job_in));

    pro_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_job_in),
        .o_full(w_full), .o_valid(w_qv), .i_pop(w_take), .o_job(w_job_out));

    pro_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_half(r_half), .i_valid(w_qv),
        .o_take(w_take), .i_job(w_job_out), .o_valid(o_valid), .i_stall(i_stall),
        .o_left_x(o_left_x), .o_left_y(o_left_y), .o_right_x(o_right_x),
        .o_right_y(o_right_y), .o_last_vertex(o_last_vertex));
endmodule
`default_nettype wire

/* rtl/pro_front.sv */
// pro_front: accepts vertices, tracks the pending vertex and builds tangent jobs.
// Depends on pro_pkg. Issues up to two jobs per item, one per cycle while the queue is not full.
`default_nettype none
module pro_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  pro_pkg::t_coord       i_point_x,
    input  pro_pkg::t_coord       i_point_y,
    input  wire                   i_last_point,
    output logic                  o_job_valid,
    input  wire                   i_job_full,
    output pro_pkg::t_job         o_job
);
    logic [1:0]       r_seen, n_seen;
    pro_pkg::t_coord  r_ax, r_ay, r_px, r_py;
    logic             r_second;
    pro_pkg::t_job    r_job2;
    logic             w_acc;
    pro_pkg::t_coord  w_fx, w_fy;

    assign o_stall = r_second || i_job_full;
    assign w_acc   = i_valid && !o_stall;

    function automatic pro_pkg::t_job mk(pro_pkg::t_coord px, pro_pkg::t_coord py,
        pro_pkg::t_coord ax, pro_pkg::t_coord ay, pro_pkg::t_coord bx,
        pro_pkg::t_coord by, logic last);
        pro_pkg::t_job j;
        logic signed [pro_pkg::DiffWidth-1:0] dx, dy;
        dx = {bx[pro_pkg::CoordWidth-1], bx} - {ax[pro_pkg::CoordWidth-1], ax};
        dy = {by[pro_pkg::CoordWidth-1], by} - {ay[pro_pkg::CoordWidth-1], ay};
        j.px = px; j.py = py; j.last = last;
        j.nx = dx[pro_pkg::DiffWidth-1];
        j.ny = dy[pro_pkg::DiffWidth-1];
        j.mx = j.nx ? -dx : dx;
        j.my = j.ny ? -dy : dy;
        return j;
    endfunction

    assign w_fx = (r_seen == 2'd1) ? r_px : r_ax;
    assign w_fy = (r_seen == 2'd1) ? r_py : r_ay;

    always_comb begin
        o_job_valid = 1'b0;
        o_job = mk(i_point_x, i_point_y, '0, '0, 32'sd1, '0, 1'b1);
        if (r_second) begin
            o_job_valid = !i_job_full;
            o_job = r_job2;
        end else if (w_acc) begin
            if (r_seen == 2'd0) begin
                o_job_valid = i_last_point;
            end else begin
                o_job_valid = 1'b1;
                o_job = mk(r_px, r_py, w_fx, w_fy, i_point_x, i_point_y, 1'b0);
            end
        end
    end

    always_comb begin
        n_seen = r_seen;
        if (w_acc) begin
            if (i_last_point) n_seen = 2'd0;
            else if (r_seen == 2'd0) n_seen = 2'd1;
            else n_seen = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 2'd0;
            r_second <= 1'b0;
        end else begin
            r_seen <= n_seen;
            if (r_second && !i_job_full) r_second <= 1'b0;
            else if (w_acc && i_last_point && r_seen != 2'd0) r_second <= 1'b1;
        end
        if (w_acc) begin
            r_ax <= r_px; r_ay <= r_py;
            r_px <= i_point_x; r_py <= i_point_y;
            r_job2 <= mk(i_point_x, i_point_y, r_px, r_py, i_point_x, i_point_y,
                         1'b1);
        end
    end
endmodule
`default_nettype wire

/* rtl/pro_ram.sv */
// pro_ram: generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module pro_ram #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(Depth)-1:0] i_waddr,
    input  wire  [Width-1:0]         i_wdata,
    input  wire  [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/pro_queue.sv */
// pro_queue: four entry job queue between front and back end.
// Depends on pro_pkg and pro_ram. Registered read feeds a one-entry output stage.
`default_nettype none
module pro_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  pro_pkg::t_job    i_job,
    output logic             o_full,
    output logic             o_valid,
    input  wire              i_pop,
    output pro_pkg::t_job    o_job
);
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       r_ov, r_pend;
    logic [pro_pkg::JobWidth-1:0] w_rd;
    pro_pkg::t_job r_hold;
    logic w_rd_en;

    pro_ram #(.Width(pro_pkg::JobWidth), .Depth(4)) u_ram (
        .i_clk(i_clk), .i_we(i_push), .i_waddr(r_wp), .i_wdata(i_job),
        .i_raddr(r_rp), .o_rdata(w_rd));

    // read issued when entries wait, no read is pending and the output stage is empty or being popped
    assign w_rd_en = (r_cnt != 3'd0) && !r_pend && (!r_ov || i_pop);
    assign o_full  = (r_cnt >= 3'd3);
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_ov <= 1'b0; r_pend <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (w_rd_en) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, i_push} - {2'b0, w_rd_en};
            r_pend <= w_rd_en;
            if (r_pend) r_ov <= 1'b1;
            else if (i_pop) r_ov <= 1'b0;
        end
        if (r_pend) r_hold <= w_rd;
    end
    assign o_job = r_hold;
endmodule
`default_nettype wire

/* rtl/pro_back.sv */
// pro_back: normalizes a tangent, takes its length by an iterative square root, divides
// each component by it and forms both saturated rail points. Depends on pro_pkg.
`default_nettype none
module pro_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire [pro_pkg::HalfWidth-1:0] i_half,
    input  wire                     i_valid,
    output logic                    o_take,
    input  pro_pkg::t_job           i_job,
    output logic                    o_valid,
    input  wire                     i_stall,
    output pro_pkg::t_coord         o_left_x,
    output pro_pkg::t_coord         o_left_y,
    output pro_pkg::t_coord         o_right_x,
    output pro_pkg::t_coord         o_right_y,
    output logic                    o_last_vertex
);
    localparam logic [3:0] S_IDLE = 4'd0, S_NORM = 4'd1, S_SQ = 4'd2,
        S_SUM = 4'd3, S_ROOT = 4'd4, S_DIVX = 4'd5, S_DIVY = 4'd6,
        S_MUL = 4'd7, S_ADD = 4'd8;
    localparam logic [63:0] One30 = 64'd1 << 30;
    localparam logic [63:0] One29 = 64'd1 << 29;
    localparam logic [43:0] Round29 = 44'd1 << 29;

    logic [3:0]  r_st;
    pro_pkg::t_job r_j;
    logic [63:0] r_mx, r_my, r_sx, r_sy, r_s, r_r, r_bit, r_num, r_q, r_rem;
    logic [63:0] r_ux, r_uy, r_ox, r_oy;
    logic [6:0]  r_cnt;
    logic        r_zero, r_ydiv;
    logic        r_ov, r_lv;
    pro_pkg::t_coord r_lx, r_ly, r_rx, r_ry;
    logic [63:0] w_big, w_rem2, w_sb;
    logic [43:0] w_hx, w_hy;

    assign o_take = (r_st == S_IDLE) && i_valid;
    assign w_big  = (r_mx > r_my) ? r_mx : r_my;
    assign w_rem2 = {r_rem[62:0], r_num[63]};
    assign w_sb   = r_r + r_bit;
    assign w_hx   = {31'b0, i_half} * {13'b0, r_uy[30:0]};
    assign w_hy   = {31'b0, i_half} * {13'b0, r_ux[30:0]};

    function automatic pro_pkg::t_coord sat(pro_pkg::t_coord p, logic [63:0] m,
                                            logic neg);
        logic signed [pro_pkg::CoordWidth+1:0] s;
        s = neg ? ({{2{p[pro_pkg::CoordWidth-1]}}, p} - $signed({2'b0, m[31:0]}))
                : ({{2{p[pro_pkg::CoordWidth-1]}}, p} + $signed({2'b0, m[31:0]}));
        if (s > $signed({3'b0, {(pro_pkg::CoordWidth-1){1'b1}}}))
            return {1'b0, {(pro_pkg::CoordWidth-1){1'b1}}};
        if (s < -$signed({3'b0, {(pro_pkg::CoordWidth-1){1'b1}}}) - 1)
            return {1'b1, {(pro_pkg::CoordWidth-1){1'b0}}};
        return s[pro_pkg::CoordWidth-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_st == S_ADD && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_j  <= i_job;
                    r_mx <= {31'b0, i_job.mx};
                    r_my <= {31'b0, i_job.my};
                    r_zero <= (i_job.mx == '0) && (i_job.my == '0);
                    r_st <= S_NORM;
                end
                S_NORM: begin
                    if (r_zero) begin
                        r_ox <= '0; r_oy <= '0; r_st <= S_ADD;
                    end else if (w_big >= One30) begin
                        r_mx <= r_mx >> 1; r_my <= r_my >> 1;
                    end else if (w_big < One29) begin
                        r_mx <= r_mx << 1; r_my <= r_my << 1;
                    end else r_st <= S_SQ;
                end
                S_SQ: begin
                    r_sx <= r_mx[31:0] * r_mx[31:0];
                    r_sy <= r_my[31:0] * r_my[31:0];
                    r_st <= S_SUM;
                end
                S_SUM: begin
                    r_s <= r_sx + r_sy; r_r <= '0; r_bit <= 64'd1 << 62;
                    r_st <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_bit == '0) begin
                        r_num <= r_mx << 30; r_rem <= '0; r_q <= '0; r_cnt <= 7'd64;
                        r_ydiv <= 1'b0; r_st <= S_DIVX;
                    end else begin
                        if (r_s >= w_sb) begin
                            r_s <= r_s - w_sb; r_r <= (r_r >> 1) + r_bit;
                        end else r_r <= r_r >> 1;
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DIVX, S_DIVY: begin
                    if (r_cnt == 7'd0) begin
                        if (!r_ydiv) begin
                            r_ux <= (r_q > One30) ? One30 : r_q;
                            r_num <= r_my << 30; r_rem <= '0; r_q <= '0;
                            r_cnt <= 7'd64; r_ydiv <= 1'b1; r_st <= S_DIVY;
                        end else begin
                            r_uy <= (r_q > One30) ? One30 : r_q;
                            r_st <= S_MUL;
                        end
                    end else begin
                        r_num <= r_num << 1;
                        if (w_rem2 >= r_r) begin
                            r_rem <= w_rem2 - r_r; r_q <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2; r_q <= {r_q[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_MUL: begin
                    r_ox <= {20'b0, (w_hx + Round29) >> 30};
                    r_oy <= {20'b0, (w_hy + Round29) >> 30};
                    r_st <= S_ADD;
                end
                S_ADD: if (!r_ov || !i_stall) begin
                    r_lx <= sat(r_j.px, r_ox, !r_j.ny);
                    r_ly <= sat(r_j.py, r_oy, r_j.nx);
                    r_rx <= sat(r_j.px, r_ox, r_j.ny);
                    r_ry <= sat(r_j.py, r_oy, !r_j.nx);
                    r_lv <= r_j.last;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_left_x = r_lx;
    assign o_left_y = r_ly;
    assign o_right_x = r_rx;
    assign o_right_y = r_ry;
    assign o_last_vertex = r_lv;
endmodule
`default_nettype wire

/* rtl/pro_checker.sv */
// pro_checker: port-level assertions for polyline_rail_offset, bound to the top.
// Depends on the top level's ports only.
`default_nettype none
module pro_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire o_valid,
    input wire i_stall,
    input wire o_last_vertex,
    input wire [31:0] o_left_x,
    input wire o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_x)) else $error("item dropped");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_last_vertex)) else $error("last changed");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready) else $error("cfg not ready");
endmodule

bind polyline_rail_offset pro_checker u_pro_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_last_vertex(o_last_vertex), .o_left_x(o_left_x), .o_cfg_ready(o_cfg_ready));
`default_nettype wire
